@@ hdl/cwpi_pkg.sv @@
// shared constants and control types for the contention window pi controller
package cwpi_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_OWN_MAC    = 3'd0;
    localparam logic [2:0] REG_TARGET     = 3'd1;
    localparam logic [2:0] REG_KP         = 3'd2;
    localparam logic [2:0] REG_KI         = 3'd3;
    localparam logic [2:0] REG_INIT       = 3'd4;
    localparam logic [2:0] REG_MIN_SAMP   = 3'd5;

    // register reset values
    localparam logic [47:0] OWN_MAC_RST   = 48'd0;
    localparam logic [16:0] TARGET_RST    = 17'd13913;
    localparam logic [23:0] KP_RST        = 24'd53207;
    localparam logic [23:0] KI_RST        = 24'd31293;
    localparam logic [23:0] INIT_RST      = 24'd137232;
    localparam logic [15:0] MIN_SAMP_RST  = 16'd20;

    // default parameter values
    localparam int COUNT_BITS_DEF = 16;
    localparam int WINDOW_MIN_DEF = 16;
    localparam int WINDOW_MAX_DEF = 1024;

    // header decode constants
    localparam logic [4:0]  MIN_HEADER    = 5'd14;
    localparam logic [1:0]  TYPE_DATA     = 2'd2;
    localparam logic [1:0]  DS_TO_AP      = 2'd1;
    localparam logic [1:0]  DS_FROM_AP    = 2'd2;
    localparam logic [47:0] BCAST_ADDR    = 48'hFFFF_FFFF_FFFF;

    // item kinds carried in tuser
    localparam logic MODE_FRAME = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic frame_go;
        logic tick_go;
        logic div_step;
        logic mul_go;
        logic sum_go;
        logic exp_go;
    } cwpi_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic total_ok;
        logic div_done;
    } cwpi_stat_t;

endpackage

@@ hdl/cwpi_ctrl.sv @@
// controller state machine sequencing the interval update
module cwpi_ctrl import cwpi_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tuser,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  cwpi_stat_t stat,
    output cwpi_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_SUM  = 5'b01000,
        ST_EXP  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    // frames pass while a result waits, ticks wait for an empty output
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || (s_tuser == MODE_FRAME));
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_tuser == MODE_FRAME)) begin
                    cmd.frame_go = 1'b1;
                end
                if (accept && (s_tuser == MODE_TICK) && stat.total_ok) begin
                    cmd.tick_go = 1'b1;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_go = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_go = 1'b1;
                state_next = ST_EXP;
            end
            ST_EXP: begin
                cmd.exp_go     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hdl/cwpi_datapath.sv @@
// counters, retry fraction divider, pi law and window exponent
module cwpi_datapath import cwpi_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int WINDOW_MIN = WINDOW_MIN_DEF,
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cwpi_cmd_t   cmd,
    output cwpi_stat_t  stat,
    input  logic [4:0]  captured_length,
    input  logic [7:0]  frame_control,
    input  logic [7:0]  frame_flags,
    input  logic [47:0] address_one,
    input  logic [47:0] address_two,
    input  logic [47:0] address_three,
    input  logic [47:0] own_mac,
    input  logic [16:0] target_probability,
    input  logic [23:0] proportional_gain,
    input  logic [23:0] integral_gain,
    input  logic [23:0] integral_init,
    input  logic        init_load,
    input  logic [15:0] min_samples,
    output logic [3:0]  window_exponent,
    output logic [10:0] window_size,
    output logic [16:0] retry_fraction
);

    localparam int NUM_W = COUNT_BITS + 17;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int CMP_W = (COUNT_BITS + 1 > 16) ? COUNT_BITS + 1 : 16;
    localparam int W_BITS = $clog2(WINDOW_MAX + 1);
    localparam int KW = $clog2(W_BITS + 1);

    logic [COUNT_BITS-1:0] retry_reg, retry_next;
    logic [COUNT_BITS-1:0] succ_reg, succ_next;
    logic [COUNT_BITS:0]   total;
    logic [15:0]           need;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic [COUNT_BITS:0]   den_reg, den_next;
    logic [COUNT_BITS:0]   rem_reg, rem_next;
    logic [COUNT_BITS+1:0] trial;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic signed [31:0]    integ_reg, integ_next;
    logic signed [17:0]    e_reg, e_next;
    logic signed [42:0]    p_reg, p_next;
    logic signed [56:0]    i_reg, i_next;
    logic signed [57:0]    sum;
    logic signed [29:0]    q, qr;
    logic [27:0]           frac_rem;
    logic                  inc;
    logic signed [32:0]    ni;
    logic [W_BITS-1:0]     w_reg, w_next;
    logic [KW-1:0]         k_floor;
    logic [2*W_BITS-1:0]   sq;
    logic [KW-1:0]         k_final;
    logic [3:0]            exp_reg;
    logic [10:0]           win_reg;
    logic [16:0]           frac_reg;
    logic [47:0]           bssid, src, dst;
    logic                  ds_ok, counts;

    // header decode and address roles
    always_comb begin
        bssid = address_one;
        src   = address_two;
        dst   = address_three;
        ds_ok = 1'b0;
        case (frame_flags[1:0])
            DS_TO_AP: begin
                ds_ok = 1'b1;
            end
            DS_FROM_AP: begin
                dst   = address_one;
                bssid = address_two;
                src   = address_three;
                ds_ok = 1'b1;
            end
            default: begin
                ds_ok = 1'b0;
            end
        endcase
    end

    assign counts = (captured_length >= MIN_HEADER) && (frame_control[3:2] == TYPE_DATA)
                    && ds_ok && (bssid == own_mac) && (src != own_mac) && (dst != BCAST_ADDR);

    // sample threshold
    assign total = {1'b0, retry_reg} + {1'b0, succ_reg};
    assign need  = (min_samples == 16'd0) ? 16'd1 : min_samples;

    // restoring divider, one quotient bit a cycle
    assign trial = {rem_reg, num_reg[NUM_W-1]};

    // status to the controller
    always_comb begin
        stat.total_ok = CMP_W'(total) >= CMP_W'(need);
        stat.div_done = (cnt_reg == CNT_W'(NUM_W - 1));
    end

    // pi law, half-to-even rounding of the q.28 sum
    assign e_next   = $signed({1'b0, num_reg[16:0]}) - $signed({1'b0, target_probability});
    assign p_next   = $signed({1'b0, proportional_gain}) * e_next;
    assign i_next   = $signed({1'b0, integral_gain}) * integ_reg;
    assign sum      = p_reg + i_reg;
    assign q        = sum[57:28];
    assign frac_rem = sum[27:0];
    assign inc      = (frac_rem > 28'h800_0000) || ((frac_rem == 28'h800_0000) && q[0]);
    assign qr       = q + 30'(inc);
    assign ni       = integ_reg + e_reg;

    // window exponent: floor log2 and the sqrt2 threshold bit of the square
    always_comb begin
        k_floor = '0;
        for (int i = 0; i < W_BITS; i++) begin
            if (w_reg[i]) begin
                k_floor = KW'(i);
            end
        end
    end
    assign sq      = w_reg * w_reg;
    assign k_final = k_floor + KW'(sq[2 * k_floor + 1]);

    // next values
    always_comb begin
        retry_next = retry_reg;
        succ_next  = succ_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        integ_next = integ_reg;
        w_next     = w_reg;
        if (cmd.frame_go && counts) begin
            if (frame_flags[3]) begin
                if (retry_reg != '1) retry_next = retry_reg + 1'b1;
            end else begin
                if (succ_reg != '1) succ_next = succ_reg + 1'b1;
            end
        end
        if (cmd.tick_go) begin
            retry_next = '0;
            succ_next  = '0;
            num_next   = NUM_W'({retry_reg, 16'd0}) + NUM_W'(total >> 1);
            den_next   = total;
            rem_next   = '0;
            cnt_next   = '0;
        end
        if (cmd.div_step) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = (COUNT_BITS+1)'(trial - {1'b0, den_reg});
                num_next = {num_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[COUNT_BITS:0];
                num_next = {num_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.sum_go) begin
            if (ni[32] != ni[31]) begin
                integ_next = {ni[32], {31{~ni[32]}}};
            end else begin
                integ_next = ni[31:0];
            end
            if (qr < $signed(30'(WINDOW_MIN))) begin
                w_next = W_BITS'(WINDOW_MIN);
            end else if (qr > $signed(30'(WINDOW_MAX))) begin
                w_next = W_BITS'(WINDOW_MAX);
            end else begin
                w_next = W_BITS'(qr);
            end
        end
        if (init_load) begin
            integ_next = 32'(signed'(integral_init));
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_reg <= '0;
            succ_reg  <= '0;
            cnt_reg   <= '0;
            integ_reg <= 32'(signed'(INIT_RST));
        end else begin
            retry_reg <= retry_next;
            succ_reg  <= succ_next;
            cnt_reg   <= cnt_next;
            integ_reg <= integ_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        w_reg   <= w_next;
        if (cmd.mul_go) begin
            e_reg <= e_next;
            p_reg <= p_next;
            i_reg <= i_next;
        end
        if (cmd.exp_go) begin
            exp_reg  <= 4'(k_final);
            win_reg  <= 11'(w_reg);
            frac_reg <= num_reg[16:0];
        end
    end

    assign window_exponent = exp_reg;
    assign window_size     = win_reg;
    assign retry_fraction  = frac_reg;

endmodule

@@ hdl/contention_window_pi_controller.sv @@
// top level: configuration registers, stream ports, controller and datapath
//
// Frame items are taken one per clock while the block is idle and update the retry
// and success counters in the cycle they are accepted; frames are also taken while
// a result waits on the output. A tick below the sample threshold is taken and
// changes nothing. An updating tick clears the counters and occupies the block
// until its result appears: the restoring divider for the retry fraction produces
// one quotient bit per cycle, followed by the gain multipliers, the rounding and
// clamping step, and the window exponent, in that order. A new tick is held off
// until the previous result has been taken. Registers lie at byte address 8*i; the
// user must write them only while the block is idle, which the block itself does
// not enforce.
module contention_window_pi_controller import cwpi_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int WINDOW_MIN = WINDOW_MIN_DEF,
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [167:0] s_tdata,  // captured_length, frame_control, frame_flags,
                                   // address_one, address_two, address_three
    input  logic         s_tuser,  // mode
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata   // window_exponent, window_size, retry_fraction
);

    logic [47:0] own_mac_reg;
    logic [16:0] target_reg;
    logic [23:0] kp_reg;
    logic [23:0] ki_reg;
    logic [23:0] init_reg;
    logic [15:0] min_samp_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;
    cwpi_cmd_t   cmd;
    cwpi_stat_t  stat;
    logic [3:0]  window_exponent;
    logic [10:0] window_size;
    logic [16:0] retry_fraction;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[5:3];

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_mac_reg  <= OWN_MAC_RST;
            target_reg   <= TARGET_RST;
            kp_reg       <= KP_RST;
            ki_reg       <= KI_RST;
            init_reg     <= INIT_RST;
            min_samp_reg <= MIN_SAMP_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_OWN_MAC:  own_mac_reg  <= pwdata[47:0];
                REG_TARGET:   target_reg   <= pwdata[16:0];
                REG_KP:       kp_reg       <= pwdata[23:0];
                REG_KI:       ki_reg       <= pwdata[23:0];
                REG_INIT:     init_reg     <= pwdata[23:0];
                REG_MIN_SAMP: min_samp_reg <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            REG_OWN_MAC:  prdata = {16'd0, own_mac_reg};
            REG_TARGET:   prdata = {47'd0, target_reg};
            REG_KP:       prdata = {40'd0, kp_reg};
            REG_KI:       prdata = {40'd0, ki_reg};
            REG_INIT:     prdata = {40'd0, init_reg};
            REG_MIN_SAMP: prdata = {48'd0, min_samp_reg};
            default:      prdata = 64'd0;
        endcase
    end

    cwpi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cwpi_datapath #(
        .COUNT_BITS (COUNT_BITS),
        .WINDOW_MIN (WINDOW_MIN),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .captured_length    (s_tdata[4:0]),
        .frame_control      (s_tdata[12:5]),
        .frame_flags        (s_tdata[20:13]),
        .address_one        (s_tdata[68:21]),
        .address_two        (s_tdata[116:69]),
        .address_three      (s_tdata[164:117]),
        .own_mac            (own_mac_reg),
        .target_probability (target_reg),
        .proportional_gain  (kp_reg),
        .integral_gain      (ki_reg),
        .integral_init      (pwdata[23:0]),
        .init_load          (wr_en && (reg_idx == REG_INIT)),
        .min_samples        (min_samp_reg),
        .window_exponent    (window_exponent),
        .window_size        (window_size),
        .retry_fraction     (retry_fraction)
    );

    assign m_tdata = {retry_fraction, window_size, window_exponent};

endmodule
